>>> hw/rtl/iacap_pkg.sv
`timescale 1ns / 1ps
package iacap_pkg;

	typedef enum logic [3:0] {
		OP_GT  = 4'd0,
		OP_GE  = 4'd1,
		OP_LT  = 4'd2,
		OP_LE  = 4'd3,
		OP_EQ  = 4'd4,
		OP_NE  = 4'd5,
		OP_ADD = 4'd6,
		OP_SUB = 4'd7,
		OP_MUL = 4'd8,
		OP_DIV = 4'd9,
		OP_POW = 4'd10
	} op_t;

	typedef enum logic [1:0] {
		KIND_IMM,
		KIND_DIV,
		KIND_POW
	} kind_t;

	typedef struct packed {
		op_t  op;
		logic neg;
		logic err;
	} fctl_t;

	typedef struct packed {
		kind_t kind;
		logic  neg;
		logic  is_bool;
		logic  err;
	} bctl_t;

endpackage

>>> hw/rtl/iacap_front.sv
`timescale 1ns / 1ps
module iacap_front #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [3:0]          op,
	input  logic signed [W-1:0] operand_a,
	input  logic signed [W-1:0] operand_b,
	input  logic                q_full,
	output logic                f_valid,
	output iacap_pkg::fctl_t    f_ctl,
	output logic [W-1:0]        f_a,
	output logic [W-1:0]        f_b,
	output logic [W-1:0]        f_amag,
	output logic [W-1:0]        f_bmag
);
	import iacap_pkg::*;

	logic         valid_s1;
	fctl_t        ctl_s1;
	logic [W-1:0] a_s1;
	logic [W-1:0] b_s1;
	logic         load;
	op_t          op_d;
	fctl_t        ctl_d;

	assign load     = !valid_s1 || !q_full;
	assign in_stall = !load;

	always_comb begin
		op_d      = op_t'(op);
		ctl_d.op  = op_d;
		ctl_d.neg = operand_a[W-1] ^ operand_b[W-1];
		ctl_d.err = ((op_d == OP_DIV) && (operand_b == '0)) ||
			((op_d == OP_POW) && operand_b[W-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			ctl_s1 <= ctl_d;
			a_s1   <= operand_a;
			b_s1   <= operand_b;
		end
	end

	assign f_valid = valid_s1;
	assign f_ctl   = ctl_s1;
	assign f_a     = a_s1;
	assign f_b     = b_s1;
	assign f_amag  = a_s1[W-1] ? (~a_s1 + 1'b1) : a_s1;
	assign f_bmag  = b_s1[W-1] ? (~b_s1 + 1'b1) : b_s1;

endmodule

>>> hw/rtl/iacap_queue.sv
`timescale 1ns / 1ps
module iacap_queue #(
	parameter int W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  iacap_pkg::fctl_t wr_ctl,
	input  logic [W-1:0]     wr_a,
	input  logic [W-1:0]     wr_b,
	input  logic [W-1:0]     wr_amag,
	input  logic [W-1:0]     wr_bmag,
	output logic             full,
	input  logic             pop,
	output logic             rd_valid,
	output iacap_pkg::fctl_t rd_ctl,
	output logic [W-1:0]     rd_a,
	output logic [W-1:0]     rd_b,
	output logic [W-1:0]     rd_amag,
	output logic [W-1:0]     rd_bmag
);
	import iacap_pkg::*;

	fctl_t        ctl_q  [0:1];
	logic [W-1:0] a_q    [0:1];
	logic [W-1:0] b_q    [0:1];
	logic [W-1:0] amag_q [0:1];
	logic [W-1:0] bmag_q [0:1];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_push;
	logic         do_pop;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ctl_q[wr_ptr_q]  <= wr_ctl;
			a_q[wr_ptr_q]    <= wr_a;
			b_q[wr_ptr_q]    <= wr_b;
			amag_q[wr_ptr_q] <= wr_amag;
			bmag_q[wr_ptr_q] <= wr_bmag;
		end
	end

	assign rd_ctl  = ctl_q[rd_ptr_q];
	assign rd_a    = a_q[rd_ptr_q];
	assign rd_b    = b_q[rd_ptr_q];
	assign rd_amag = amag_q[rd_ptr_q];
	assign rd_bmag = bmag_q[rd_ptr_q];

endmodule

>>> hw/rtl/iacap_back.sv
`timescale 1ns / 1ps
module iacap_back #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  iacap_pkg::fctl_t    q_ctl,
	input  logic [W-1:0]        q_a,
	input  logic [W-1:0]        q_b,
	input  logic [W-1:0]        q_amag,
	input  logic [W-1:0]        q_bmag,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [W-1:0] value,
	output logic                is_boolean,
	output logic                error
);
	import iacap_pkg::*;

	logic         vld_s  [0:W];
	bctl_t        ctl_s  [0:W];
	logic [W-1:0] acc_s  [0:W];
	logic [W-1:0] base_s [0:W];
	logic [W-1:0] arg_s  [0:W];

	logic           adv;
	bctl_t          ctl_d;
	logic [W-1:0]   acc_d;
	logic [W-1:0]   base_d;
	logic [W-1:0]   arg_d;
	logic [2*W-1:0] prod_d;

	assign adv = !vld_s[W] || !out_stall;
	assign pop = adv && q_valid;

	always_comb begin
		ctl_d.kind    = KIND_IMM;
		ctl_d.neg     = q_ctl.neg;
		ctl_d.is_bool = 1'b0;
		ctl_d.err     = q_ctl.err;
		acc_d         = '0;
		base_d        = '0;
		arg_d         = '0;
		prod_d        = q_a * q_b;
		unique case (q_ctl.op)
			OP_GT: begin
				ctl_d.is_bool = 1'b1;
				acc_d[0]      = $signed(q_a) > $signed(q_b);
			end
			OP_GE: begin
				ctl_d.is_bool = 1'b1;
				acc_d[0]      = $signed(q_a) >= $signed(q_b);
			end
			OP_LT: begin
				ctl_d.is_bool = 1'b1;
				acc_d[0]      = $signed(q_a) < $signed(q_b);
			end
			OP_LE: begin
				ctl_d.is_bool = 1'b1;
				acc_d[0]      = $signed(q_a) <= $signed(q_b);
			end
			OP_EQ: begin
				ctl_d.is_bool = 1'b1;
				acc_d[0]      = (q_a == q_b);
			end
			OP_NE: begin
				ctl_d.is_bool = 1'b1;
				acc_d[0]      = (q_a != q_b);
			end
			OP_ADD: acc_d = q_a + q_b;
			OP_SUB: acc_d = q_a - q_b;
			OP_MUL: acc_d = prod_d[W-1:0];
			OP_DIV: begin
				if (!q_ctl.err) begin
					ctl_d.kind = KIND_DIV;
					base_d     = q_amag;
					arg_d      = q_bmag;
				end
			end
			OP_POW: begin
				if (!q_ctl.err) begin
					ctl_d.kind = KIND_POW;
					acc_d      = {{(W-1){1'b0}}, 1'b1};
					base_d     = q_a;
					arg_d      = q_b;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ctl_s[0]  <= ctl_d;
			acc_s[0]  <= acc_d;
			base_s[0] <= base_d;
			arg_s[0]  <= arg_d;
		end
	end

	for (genvar i = 1; i <= W; i++) begin : g_step
		logic [W:0]     rem;
		logic [W:0]     diff;
		logic           ge;
		logic [2*W-1:0] mul_ab;
		logic [2*W-1:0] mul_bb;
		logic [W-1:0]   n_acc;
		logic [W-1:0]   n_base;
		logic [W-1:0]   n_arg;

		always_comb begin
			rem    = {acc_s[i-1], base_s[i-1][W-1]};
			diff   = rem - {1'b0, arg_s[i-1]};
			ge     = (rem >= {1'b0, arg_s[i-1]});
			mul_ab = acc_s[i-1] * base_s[i-1];
			mul_bb = base_s[i-1] * base_s[i-1];
			n_acc  = acc_s[i-1];
			n_base = base_s[i-1];
			n_arg  = arg_s[i-1];
			case (ctl_s[i-1].kind)
				KIND_DIV: begin
					n_acc  = ge ? diff[W-1:0] : rem[W-1:0];
					n_base = {base_s[i-1][W-2:0], ge};
				end
				KIND_POW: begin
					if (arg_s[i-1][0]) begin
						n_acc = mul_ab[W-1:0];
					end
					n_base = mul_bb[W-1:0];
					n_arg  = {1'b0, arg_s[i-1][W-1:1]};
				end
				default: ;
			endcase
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv && vld_s[i-1]) begin
				ctl_s[i]  <= ctl_s[i-1];
				acc_s[i]  <= n_acc;
				base_s[i] <= n_base;
				arg_s[i]  <= n_arg;
			end
		end
	end

	assign out_valid  = vld_s[W];
	assign is_boolean = ctl_s[W].is_bool;
	assign error      = ctl_s[W].err;
	assign value      = (ctl_s[W].kind == KIND_DIV) ?
		(ctl_s[W].neg ? (~base_s[W] + 1'b1) : base_s[W]) : acc_s[W];

endmodule

>>> hw/rtl/integer_alu_compare_arith_power_core.sv
// Throughput: one word per cycle unless out_stall or a full queue stalls the flow;
// the divide and power step pipeline of DATA_WIDTH stages, one quotient bit or one
// exponent bit per stage, sets the depth.
// A two-entry queue sits between the decode front and the execution pipeline.
// Reset (arst_n, async, active low) clears valid bits and queue pointers and count.
`timescale 1ns / 1ps
module integer_alu_compare_arith_power_core #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [3:0]                   op,
	input  logic signed [DATA_WIDTH-1:0] operand_a,
	input  logic signed [DATA_WIDTH-1:0] operand_b,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] value,
	output logic                         is_boolean,
	output logic                         error
);
	import iacap_pkg::*;

	logic                  f_valid;
	fctl_t                 f_ctl;
	logic [DATA_WIDTH-1:0] f_a;
	logic [DATA_WIDTH-1:0] f_b;
	logic [DATA_WIDTH-1:0] f_amag;
	logic [DATA_WIDTH-1:0] f_bmag;
	logic                  q_full;
	logic                  q_valid;
	logic                  q_pop;
	fctl_t                 q_ctl;
	logic [DATA_WIDTH-1:0] q_a;
	logic [DATA_WIDTH-1:0] q_b;
	logic [DATA_WIDTH-1:0] q_amag;
	logic [DATA_WIDTH-1:0] q_bmag;

	iacap_front #(.W(DATA_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.q_full    (q_full),
		.f_valid   (f_valid),
		.f_ctl     (f_ctl),
		.f_a       (f_a),
		.f_b       (f_b),
		.f_amag    (f_amag),
		.f_bmag    (f_bmag)
	);

	iacap_queue #(.W(DATA_WIDTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_valid),
		.wr_ctl   (f_ctl),
		.wr_a     (f_a),
		.wr_b     (f_b),
		.wr_amag  (f_amag),
		.wr_bmag  (f_bmag),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_ctl   (q_ctl),
		.rd_a     (q_a),
		.rd_b     (q_b),
		.rd_amag  (q_amag),
		.rd_bmag  (q_bmag)
	);

	iacap_back #(.W(DATA_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_ctl      (q_ctl),
		.q_a        (q_a),
		.q_b        (q_b),
		.q_amag     (q_amag),
		.q_bmag     (q_bmag),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.is_boolean (is_boolean),
		.error      (error)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (f_valid && q_full))
		else $error("input stalled without a full queue");

	a_bool_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_boolean) |-> (value[DATA_WIDTH-1:1] == '0))
		else $error("boolean word out of range");

	a_bool_noerr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_boolean) |-> !error)
		else $error("boolean word flagged as error");

endmodule

>>> bench/alu_result_checker.sv
`timescale 1ns / 1ps
module alu_result_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [3:0]         op,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] value,
	input  logic               is_boolean,
	input  logic               error,
	output int                 fail_count,
	output int                 pending
);
	import iacap_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic        is_boolean;
		logic        error;
	} alu_result_t;

	alu_result_t expected_q[$];

	function automatic logic [31:0] raise_power(logic [31:0] base, logic [31:0] expo);
		logic [31:0] acc;
		acc = 32'd1;
		for (int i = 0; i < 32; i++) begin
			if (expo[i])
				acc = acc * base;
			base = base * base;
		end
		return acc;
	endfunction

	function automatic alu_result_t compute_result(logic [3:0] code, logic signed [31:0] a,
			logic signed [31:0] b);
		alu_result_t r;
		logic [31:0] ma, mb, q;
		r = '0;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		case (code)
			OP_GT: begin r.value = {31'd0, a > b}; r.is_boolean = 1'b1; end
			OP_GE: begin r.value = {31'd0, a >= b}; r.is_boolean = 1'b1; end
			OP_LT: begin r.value = {31'd0, a < b}; r.is_boolean = 1'b1; end
			OP_LE: begin r.value = {31'd0, a <= b}; r.is_boolean = 1'b1; end
			OP_EQ: begin r.value = {31'd0, a == b}; r.is_boolean = 1'b1; end
			OP_NE: begin r.value = {31'd0, a != b}; r.is_boolean = 1'b1; end
			OP_ADD: r.value = a + b;
			OP_SUB: r.value = a - b;
			OP_MUL: r.value = a * b;
			OP_DIV: begin
				if (b == 0)
					r.error = 1'b1;
				else begin
					q = ma / mb;
					r.value = (a[31] != b[31]) ? -q : q;
				end
			end
			OP_POW: begin
				if (b[31])
					r.error = 1'b1;
				else
					r.value = raise_power(a, b);
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	assign pending = expected_q.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		alu_result_t e;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_q.push_back(compute_result(op, operand_a, operand_b));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					fail_count <= fail_count + 1;
					$display("%0t: unexpected word value=%h", $time, value);
				end else begin
					e = expected_q.pop_front();
					if (e.value !== value || e.is_boolean !== is_boolean || e.error !== error) begin
						fail_count <= fail_count + 1;
						$display("%0t: expected value=%h bool=%b err=%b, got value=%h bool=%b err=%b",
							$time, e.value, e.is_boolean, e.error, value, is_boolean, error);
					end
				end
			end
		end
	end

endmodule

>>> bench/tb_integer_alu_compare_arith_power_core.sv
`timescale 1ns / 1ps
module tb_integer_alu_compare_arith_power_core;
	import iacap_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [3:0]         op = '0;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] value;
	logic               is_boolean;
	logic               error;
	int                 fail_count;
	int                 pending;
	int                 hold_cycles = 0;
	bit                 steady = 1'b0;

	localparam logic signed [31:0] MIN_INT = 32'sh8000_0000;
	localparam logic signed [31:0] MAX_INT = 32'sh7fff_ffff;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	integer_alu_compare_arith_power_core #(.DATA_WIDTH(32)) DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .op(op),
		.operand_a(operand_a), .operand_b(operand_b), .out_valid(out_valid),
		.out_stall(out_stall), .value(value), .is_boolean(is_boolean), .error(error)
	);

	alu_result_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .op(op),
		.operand_a(operand_a), .operand_b(operand_b), .out_valid(out_valid),
		.out_stall(out_stall), .value(value), .is_boolean(is_boolean), .error(error),
		.fail_count(fail_count), .pending(pending)
	);

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return MIN_INT;
			1: return MAX_INT;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, 3);
			4, 5: return $signed($urandom_range(0, 40)) - 20;
			default: return $urandom;
		endcase
	endfunction

	// hold the receiver off for a long stretch on request, else stall it at random unless steady
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 26);
	end

	task automatic send_word(logic [3:0] code, logic [31:0] a, logic [31:0] b);
		while (!steady && $urandom_range(0, 99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic random_word();
		logic [3:0] code;
		logic [31:0] b;
		code = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15)) :
			4'($urandom_range(0, 10));
		b = pick_operand();
		if (code == OP_POW && $urandom_range(0, 3) != 0)
			b = $urandom_range(0, 40);
		send_word(code, pick_operand(), b);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int c = OP_GT; c <= OP_NE; c++) begin
			send_word(4'(c), MIN_INT, MAX_INT);
			send_word(4'(c), 32'sd5, 32'sd5);
		end
		send_word(OP_ADD, MAX_INT, 32'sd1);
		send_word(OP_SUB, MIN_INT, 32'sd1);
		send_word(OP_MUL, MAX_INT, MAX_INT);
		send_word(OP_DIV, 32'sd7, 32'sd0);
		send_word(OP_DIV, MIN_INT, -32'sd1);
		send_word(OP_DIV, -32'sd7, 32'sd2);
		send_word(OP_POW, 32'sd3, -32'sd1);
		send_word(OP_POW, 32'sd0, 32'sd0);
		send_word(OP_POW, -32'sd3, 32'sd13);
		send_word(4'd15, 32'hffff_ffff, 32'hffff_ffff);
		send_word(4'd11, 32'sd1, 32'sd2);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending > 0)
			@(posedge clk);
		hold_cycles <= 120;
		for (int i = 0; i < 80; i++)
			random_word();
		steady = 1'b1;
		for (int i = 0; i < 150; i++)
			random_word();
		steady = 1'b0;
		for (int i = 0; i < 820; i++)
			random_word();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#200000;
		$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/iacap_pkg.sv
hw/rtl/iacap_front.sv
hw/rtl/iacap_queue.sv
hw/rtl/iacap_back.sv
hw/rtl/integer_alu_compare_arith_power_core.sv
bench/alu_result_checker.sv
bench/tb_integer_alu_compare_arith_power_core.sv
